### rtl/core/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_AT(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block clock clk and reset arst_n.
`define ASSERT_CLK(lbl, prop, msg) \
	`ASSERT_AT(lbl, clk, arst_n, prop, msg)

`endif

### rtl/core/ltvcap_pkg.sv
// Package with the shared types and constants of the capability parser.
package ltvcap_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       is_zero;
	} qitem_t;

endpackage

### rtl/core/ltvcap_front.sv
// Front end: accepts record bytes, tags them, and queues them for the parser.
module ltvcap_front #(
	parameter int unsigned QUEUE_DEPTH = ltvcap_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	output ltvcap_pkg::qitem_t  head,
	output logic                head_valid,
	input  logic                head_pop
);
	import ltvcap_pkg::*;

	localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

	qitem_t          mem_q [QUEUE_DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            push;
	logic            pop;
	qitem_t          wr_item;

	assign item_stall = (count_q == CntFull);
	assign head_valid = (count_q != '0);
	assign push       = item_valid && !item_stall;
	assign pop        = head_pop && head_valid;
	assign head       = mem_q[rd_ptr_q];

	always_comb begin
		wr_item.data    = data_byte;
		wr_item.last    = last_byte;
		wr_item.is_zero = (data_byte == 8'd0);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

### rtl/core/ltvcap_back.sv
// Back end: walks the length-type-value elements and registers the result.
module ltvcap_back (
	input  logic               clk,
	input  logic               arst_n,
	input  ltvcap_pkg::qitem_t head,
	input  logic               head_valid,
	output logic               head_pop,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [15:0]        sampling_freqs,
	output logic [7:0]         frame_durations,
	output logic [7:0]         channel_counts,
	output logic [15:0]        min_octets,
	output logic [15:0]        max_octets,
	output logic [7:0]         frames_per_sdu,
	output logic               truncated
);
	import ltvcap_pkg::*;

	localparam logic [1:0] PH_LEN  = 2'd0;
	localparam logic [1:0] PH_TYPE = 2'd1;
	localparam logic [1:0] PH_VAL  = 2'd2;

	localparam logic [7:0] TYPE_FREQ     = 8'd1;
	localparam logic [7:0] TYPE_DURATION = 8'd2;
	localparam logic [7:0] TYPE_COUNT    = 8'd3;
	localparam logic [7:0] TYPE_OCTETS   = 8'd4;
	localparam logic [7:0] TYPE_SDU      = 8'd5;

	logic [1:0]  phase_q, phase_n;
	logic [7:0]  left_q, left_n;
	logic [7:0]  type_q, type_n;
	logic [31:0] value_q, value_n;
	logic [2:0]  pos_q, pos_n;
	logic [15:0] freq_q, freq_n;
	logic [7:0]  dur_q, dur_n;
	logic [7:0]  cnt_q, cnt_n;
	logic [15:0] min_q, min_n;
	logic [15:0] max_q, max_n;
	logic [7:0]  sdu_q, sdu_n;
	logic        finish;
	logic        take;
	logic        result_valid_q;

	assign take         = head_valid && (!result_valid_q || !result_stall);
	assign head_pop     = take;
	assign result_valid = result_valid_q;

	always_comb begin
		phase_n = phase_q;
		left_n  = left_q;
		type_n  = type_q;
		value_n = value_q;
		pos_n   = pos_q;
		freq_n  = freq_q;
		dur_n   = dur_q;
		cnt_n   = cnt_q;
		min_n   = min_q;
		max_n   = max_q;
		sdu_n   = sdu_q;
		finish  = 1'b0;
		unique case (phase_q)
			PH_TYPE: begin
				type_n  = head.data;
				value_n = '0;
				pos_n   = '0;
				if (left_q == 8'd0) begin
					finish = 1'b1;
				end else begin
					phase_n = PH_VAL;
				end
			end
			PH_VAL: begin
				if (!pos_q[2]) begin
					value_n = value_q | (32'(head.data) << {pos_q[1:0], 3'b000});
					pos_n   = pos_q + 3'd1;
				end
				left_n = left_q - 8'd1;
				if (left_n == 8'd0) begin
					finish = 1'b1;
				end
			end
			default: begin
				if (head.is_zero) begin
					phase_n = PH_LEN;
				end else begin
					left_n  = head.data - 8'd1;
					phase_n = PH_TYPE;
				end
			end
		endcase
		if (finish) begin
			phase_n = PH_LEN;
			unique case (type_n)
				TYPE_FREQ:     freq_n = value_n[15:0];
				TYPE_DURATION: dur_n  = value_n[7:0];
				TYPE_COUNT:    cnt_n  = value_n[7:0];
				TYPE_OCTETS: begin
					min_n = value_n[15:0];
					max_n = value_n[31:16];
				end
				TYPE_SDU:      sdu_n  = value_n[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_LEN;
			left_q         <= '0;
			type_q         <= '0;
			value_q        <= '0;
			pos_q          <= '0;
			freq_q         <= '0;
			dur_q          <= '0;
			cnt_q          <= '0;
			min_q          <= '0;
			max_q          <= '0;
			sdu_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (take && head.last) begin
				phase_q        <= PH_LEN;
				left_q         <= '0;
				type_q         <= '0;
				value_q        <= '0;
				pos_q          <= '0;
				freq_q         <= '0;
				dur_q          <= '0;
				cnt_q          <= '0;
				min_q          <= '0;
				max_q          <= '0;
				sdu_q          <= '0;
				result_valid_q <= 1'b1;
			end else begin
				if (take) begin
					phase_q <= phase_n;
					left_q  <= left_n;
					type_q  <= type_n;
					value_q <= value_n;
					pos_q   <= pos_n;
					freq_q  <= freq_n;
					dur_q   <= dur_n;
					cnt_q   <= cnt_n;
					min_q   <= min_n;
					max_q   <= max_n;
					sdu_q   <= sdu_n;
				end
				if (result_valid_q && !result_stall) begin
					result_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && head.last) begin
			sampling_freqs  <= freq_n;
			frame_durations <= dur_n;
			channel_counts  <= cnt_n;
			min_octets      <= min_n;
			max_octets      <= max_n;
			frames_per_sdu  <= sdu_n;
			truncated       <= (phase_n == PH_TYPE) || (phase_n == PH_VAL);
		end
	end

endmodule

### rtl/core/ltv_codec_capability_parser.sv
// Top level of the codec capability parser: byte queue followed by the element parser.
// A byte accepted into the byte queue is parsed once it reaches the queue head; the
// result is registered when the element parser takes that record's last byte.
// Throughput is one byte per cycle from the element parser while no result is stalled.
// The byte queue absorbs up to QUEUE_DEPTH bytes while a result is stalled.
// Reset empties the queue and clears the parser state and fields, not the result outputs.
module ltv_codec_capability_parser #(
	parameter int unsigned QUEUE_DEPTH = ltvcap_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [15:0] sampling_freqs,
	output logic [7:0]  frame_durations,
	output logic [7:0]  channel_counts,
	output logic [15:0] min_octets,
	output logic [15:0] max_octets,
	output logic [7:0]  frames_per_sdu,
	output logic        truncated
);
	import ltvcap_pkg::*;

	qitem_t head;
	logic   head_valid;
	logic   head_pop;

	ltvcap_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.head       (head),
		.head_valid (head_valid),
		.head_pop   (head_pop)
	);

	ltvcap_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head            (head),
		.head_valid      (head_valid),
		.head_pop        (head_pop),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.sampling_freqs  (sampling_freqs),
		.frame_durations (frame_durations),
		.channel_counts  (channel_counts),
		.min_octets      (min_octets),
		.max_octets      (max_octets),
		.frames_per_sdu  (frames_per_sdu),
		.truncated       (truncated)
	);

endmodule

### rtl/core/ltvcap_checker.sv
// Port-level assertion checker for the codec capability parser, with its bind.
`include "assert_macros.svh"

module ltvcap_checker #(
	parameter int unsigned QUEUE_DEPTH = ltvcap_pkg::QUEUE_DEPTH
) (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_stall,
	input logic        last_byte,
	input logic        result_valid,
	input logic        result_stall,
	input logic [15:0] sampling_freqs,
	input logic [7:0]  frame_durations,
	input logic [7:0]  channel_counts,
	input logic [15:0] min_octets,
	input logic [15:0] max_octets,
	input logic [7:0]  frames_per_sdu,
	input logic        truncated
);
	localparam int unsigned PendW = $clog2(QUEUE_DEPTH + 3);
	localparam logic [PendW-1:0] PendMax = PendW'(QUEUE_DEPTH + 1);

	logic [PendW-1:0] pend_q;
	logic             rec_in;
	logic             rec_out;
	logic             res_held;
	logic [72:0]      result_bus;

	assign rec_in     = item_valid && !item_stall && last_byte;
	assign rec_out    = result_valid && !result_stall;
	assign res_held   = result_valid && result_stall;
	assign result_bus = {sampling_freqs, frame_durations, channel_counts, min_octets,
		max_octets, frames_per_sdu, truncated};

	// Count records whose last byte went in and whose result has not yet come out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (rec_in && !rec_out) begin
			pend_q <= pend_q + PendW'(1);
		end else if (rec_out && !rec_in) begin
			pend_q <= pend_q - PendW'(1);
		end
	end

	`ASSERT_CLK(a_result_has_record, result_valid |-> (pend_q != '0), "result without a record")
	`ASSERT_CLK(a_pending_bounded, pend_q <= PendMax, "too many records pending")
	`ASSERT_CLK(a_result_valid_holds, res_held |=> result_valid, "result valid dropped")
	`ASSERT_CLK(a_result_payload_holds, res_held |=> $stable(result_bus), "result payload moved")

endmodule

bind ltv_codec_capability_parser ltvcap_checker #(
	.QUEUE_DEPTH(QUEUE_DEPTH)
) u_ltvcap_checker (.*);

### verif/cap_record_check_pkg.sv
// Expected-result tracker for the codec capability parser: a byte-level predictor and checker.
package cap_record_check_pkg;

	typedef enum logic [1:0] {
		EXPECT_LENGTH = 2'd0,
		EXPECT_TYPE   = 2'd1,
		VALUE_BYTES   = 2'd2
	} ltv_phase_t;

	localparam logic [7:0] TYPE_SAMPLING_FREQ    = 8'd1;
	localparam logic [7:0] TYPE_FRAME_DURATION   = 8'd2;
	localparam logic [7:0] TYPE_CHANNEL_COUNT    = 8'd3;
	localparam logic [7:0] TYPE_OCTETS_PER_FRAME = 8'd4;
	localparam logic [7:0] TYPE_FRAMES_PER_SDU   = 8'd5;

	typedef struct packed {
		logic [15:0] sampling_freqs;
		logic [7:0]  frame_durations;
		logic [7:0]  channel_counts;
		logic [15:0] min_octets;
		logic [15:0] max_octets;
		logic [7:0]  frames_per_sdu;
		logic        truncated;
	} cap_record_t;

	class capability_tracker;
		ltv_phase_t  phase;
		logic [7:0]  bytes_left;
		logic [7:0]  element_type;
		logic [31:0] value_acc;
		logic [2:0]  value_count;
		cap_record_t captured;
		cap_record_t expected_records[$];
		int unsigned mismatch_count;

		function new();
			mismatch_count = 0;
			clear();
		endfunction

		function void clear();
			phase = EXPECT_LENGTH;
			bytes_left = '0;
			element_type = '0;
			value_acc = '0;
			value_count = '0;
			captured = '0;
		endfunction

		function void close_element();
			case (element_type)
				TYPE_SAMPLING_FREQ: captured.sampling_freqs = value_acc[15:0];
				TYPE_FRAME_DURATION: captured.frame_durations = value_acc[7:0];
				TYPE_CHANNEL_COUNT: captured.channel_counts = value_acc[7:0];
				TYPE_OCTETS_PER_FRAME: begin
					captured.min_octets = value_acc[15:0];
					captured.max_octets = value_acc[31:16];
				end
				TYPE_FRAMES_PER_SDU: captured.frames_per_sdu = value_acc[7:0];
				default: ;
			endcase
			phase = EXPECT_LENGTH;
		endfunction

		function void take_byte(logic [7:0] b, logic last);
			cap_record_t result;
			case (phase)
				EXPECT_TYPE: begin
					element_type = b;
					value_acc = '0;
					value_count = '0;
					if (bytes_left == 8'd0) close_element();
					else phase = VALUE_BYTES;
				end
				VALUE_BYTES: begin
					if (value_count < 3'd4) begin
						value_acc = value_acc | ({24'd0, b} << (8 * value_count));
						value_count = value_count + 3'd1;
					end
					bytes_left = bytes_left - 8'd1;
					if (bytes_left == 8'd0) close_element();
				end
				default: begin
					if (b == 8'd0) begin
						phase = EXPECT_LENGTH;
					end else begin
						bytes_left = b - 8'd1;
						phase = EXPECT_TYPE;
					end
				end
			endcase
			if (last) begin
				result = captured;
				result.truncated = (phase != EXPECT_LENGTH);
				expected_records.push_back(result);
				clear();
			end
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
				mismatch_count++;
			end
		endfunction

		function void check_record(cap_record_t got);
			cap_record_t want;
			if (expected_records.size() == 0) begin
				$error("result transaction arrived with no record pending");
				mismatch_count++;
				return;
			end
			want = expected_records.pop_front();
			compare_field("sampling_freqs", want.sampling_freqs, got.sampling_freqs);
			compare_field("frame_durations", want.frame_durations, got.frame_durations);
			compare_field("channel_counts", want.channel_counts, got.channel_counts);
			compare_field("min_octets", want.min_octets, got.min_octets);
			compare_field("max_octets", want.max_octets, got.max_octets);
			compare_field("frames_per_sdu", want.frames_per_sdu, got.frames_per_sdu);
			compare_field("truncated", want.truncated, got.truncated);
		endfunction
	endclass

endpackage

### verif/tb_top.sv
// Testbench top for the codec capability parser: record stimulus, random idling and checking.
module tb_top;
	import cap_record_check_pkg::*;

	localparam int unsigned BYTE_TARGET = 1650;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES = 20;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid;
	logic        item_stall;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        result_valid;
	logic        result_stall;
	logic [15:0] sampling_freqs;
	logic [7:0]  frame_durations;
	logic [7:0]  channel_counts;
	logic [15:0] min_octets;
	logic [15:0] max_octets;
	logic [7:0]  frames_per_sdu;
	logic        truncated;

	capability_tracker records = new();
	logic [7:0]  record_bytes[$];
	int unsigned sent_bytes = 0;
	int unsigned send_mode = 0;
	int unsigned take_mode = 0;
	int unsigned idle_cycles = 0;

	ltv_codec_capability_parser DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.data_byte      (data_byte),
		.last_byte      (last_byte),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.sampling_freqs (sampling_freqs),
		.frame_durations(frame_durations),
		.channel_counts (channel_counts),
		.min_octets     (min_octets),
		.max_octets     (max_octets),
		.frames_per_sdu (frames_per_sdu),
		.truncated      (truncated)
	);

	always #5 clk = ~clk;

	function automatic int unsigned draw_gap(int unsigned mode);
		case (mode)
			0: return 0;
			1: return $urandom_range(0, 17);
			default: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 17) : 0;
		endcase
	endfunction

	function automatic int unsigned natural_value_len(logic [7:0] etype);
		case (etype)
			TYPE_SAMPLING_FREQ: return 2;
			TYPE_OCTETS_PER_FRAME: return 4;
			default: return 1;
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] value, input logic final_byte);
		int unsigned gap;
		gap = draw_gap(send_mode);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		data_byte <= value;
		last_byte <= final_byte;
		do @(posedge clk); while (item_stall);
		records.take_byte(value, final_byte);
		sent_bytes++;
		@(negedge clk);
	endtask

	task automatic send_record();
		if ($urandom_range(0, 7) == 0) send_mode = $urandom_range(0, 2);
		foreach (record_bytes[i]) send_byte(record_bytes[i], i == record_bytes.size() - 1);
	endtask

	task automatic build_record();
		int unsigned kind;
		int unsigned sel;
		int unsigned vlen;
		int unsigned partial;
		logic [7:0] etype;
		record_bytes.delete();
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			repeat ($urandom_range(1, 10)) record_bytes.push_back(8'($urandom_range(0, 255)));
			return;
		end
		repeat ($urandom_range(0, 6)) begin
			sel = $urandom_range(0, 19);
			if (sel == 0) begin
				record_bytes.push_back(8'd0);
			end else begin
				etype = (sel < 3) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(1, 5));
				if (sel == 3) vlen = $urandom_range(0, 40);
				else if (sel < 7) vlen = $urandom_range(0, 6);
				else vlen = natural_value_len(etype);
				record_bytes.push_back(8'(vlen + 1));
				record_bytes.push_back(etype);
				repeat (vlen) record_bytes.push_back(8'($urandom_range(0, 255)));
			end
		end
		if (kind == 1) begin
			vlen = $urandom_range(1, 12);
			partial = $urandom_range(0, vlen - 1);
			record_bytes.push_back(8'(vlen));
			if (partial != 0) record_bytes.push_back(8'($urandom_range(1, 5)));
			repeat ((partial > 1) ? partial - 1 : 0)
				record_bytes.push_back(8'($urandom_range(0, 255)));
		end
		if (record_bytes.size() == 0) record_bytes.push_back(8'd0);
	endtask

	initial begin
		item_valid = 1'b0;
		data_byte = 8'd0;
		last_byte = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		record_bytes = {8'h03, TYPE_SAMPLING_FREQ, 8'hFF, 8'hFF, 8'h02, TYPE_FRAME_DURATION,
			8'h80, 8'h06, TYPE_OCTETS_PER_FRAME, 8'h11, 8'h22, 8'h33, 8'h44, 8'hFF,
			8'h01, TYPE_CHANNEL_COUNT, 8'h02, TYPE_FRAME_DURATION, 8'h01};
		send_record();
		record_bytes = {8'h00, 8'h02, TYPE_FRAMES_PER_SDU, 8'h7F, 8'h02, 8'hFE, 8'h00, 8'hFF};
		send_record();
		record_bytes = {8'h00};
		send_record();

		while (sent_bytes < BYTE_TARGET) begin
			build_record();
			send_record();
		end
		item_valid <= 1'b0;

		while (records.expected_records.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (records.mismatch_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		int unsigned gap;
		cap_record_t got;
		result_stall = 1'b1;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 15) == 0) take_mode = $urandom_range(0, 2);
			gap = draw_gap(take_mode);
			if (gap != 0) begin
				result_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
			got.sampling_freqs = sampling_freqs;
			got.frame_durations = frame_durations;
			got.channel_counts = channel_counts;
			got.min_octets = min_octets;
			got.max_octets = max_octets;
			got.frames_per_sdu = frames_per_sdu;
			got.truncated = truncated;
			records.check_record(got);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
